// ----- src/pnpt_pkg.sv -----
`default_nettype none
package pnpt_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 40;
  localparam logic [13:0] MinFrame = 14'd14;

  localparam logic [CfgIdxW-1:0] REG_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAXLEN = 2'd2;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_TAKE = 2'd1;
  localparam logic [1:0] CMD_SWEEP = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_TAKEN = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_EXPIRED = 3'd5;
  localparam logic [2:0] ST_SWEEP_DONE = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] router_id;
    logic [15:0] neighbor_interface;
    logic [31:0] next_hop_address;
    logic [15:0] ingress_interface;
    logic [15:0] ingress_port_number;
    logic [7:0]  hop_count;
    logic [15:0] expected_egress;
    logic [31:0] frame_handle;
    logic [13:0] frame_length;
    logic [63:0] now_time;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        last;
    logic [15:0] out_ingress_interface;
    logic [15:0] out_ingress_port;
    logic [7:0]  out_hop_count;
    logic [15:0] out_expected_egress;
    logic [31:0] out_frame_handle;
    logic [13:0] out_frame_length;
    logic [63:0] out_queued_time;
    logic [5:0]  expired_total;
    logic [5:0]  occupancy;
  } out_beat_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] router;
    logic [15:0] nbr_if;
    logic [31:0] next_hop;
    logic [15:0] ingress_if;
    logic [15:0] rx_port;
    logic [15:0] egress;
    logic [7:0]  hops;
    logic [31:0] handle;
    logic [13:0] length;
    logic [63:0] qtime;
  } slot_t;

endpackage
`default_nettype wire

// ----- src/pnpt_cell.sv -----
`default_nettype none
module pnpt_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift,
  input  wire pnpt_pkg::slot_t prev_slot,
  output pnpt_pkg::slot_t      slot
);
  import pnpt_pkg::*;

  slot_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else if (shift) begin
      slot_r <= prev_slot;
    end
  end

  assign slot = slot_r;
endmodule
`default_nettype wire

// ----- src/pending_neighbor_packet_table.sv -----
`default_nettype none
// channel | direction | ports
// input   | in        | in_valid, in_ready, in_data (in_beat_t)
// result  | out       | out_valid, out_ready, out_data (out_beat_t)
// config  | in        | cfg_we, cfg_index, cfg_wdata
// take, sweep and overflowing enqueue: the beat is accepted, the ring makes one full
// pass of shifts and the closing result is loaded in S_OUT; an accepted enqueue rotates
// the ring a second time to write its slot; bad fields and CMD_NONE answer at once.
// slot i is the entry at the head (last cell) on the i-th shift of a pass.
// reset clears every valid bit at once; expired beats stall the ring while a result is held and out_ready is low.
module pending_neighbor_packet_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire pnpt_pkg::in_beat_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output pnpt_pkg::out_beat_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [pnpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pnpt_pkg::CfgDataW-1:0] cfg_wdata
);
  import pnpt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  state_t    state_r, state_nxt;
  in_beat_t  cmd_r, cmd_nxt;
  out_beat_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic [IdxW-1:0] pos_r, pos_nxt;
  logic [CntW-1:0] same_r, used_r, removed_r;
  logic [CntW-1:0] same_nxt, used_nxt, removed_nxt;
  logic      have_free_r, taken_r;
  logic      have_free_nxt, taken_nxt;
  logic [IdxW-1:0] free_pos_r, free_pos_nxt;
  logic [5:0]  limit_r;
  logic [39:0] timeout_r;
  logic [13:0] maxlen_r;

  slot_t cells [TableDepth];
  slot_t feed;
  slot_t head;
  logic  shift;

  assign head = cells[TableDepth-1];

  genvar g;
  generate
    for (g = 0; g < TableDepth; g++) begin : g_cell
      if (g == 0) begin : g_first
        pnpt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                          .prev_slot(feed), .slot(cells[g]));
      end else begin : g_rest
        pnpt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                          .prev_slot(cells[g-1]), .slot(cells[g]));
      end
    end
  endgenerate

  // head key match and age test
  logic key_hit, aged;
  logic [63:0] age;
  assign key_hit = head.valid && head.router == cmd_r.router_id &&
                   head.nbr_if == cmd_r.neighbor_interface &&
                   head.next_hop == cmd_r.next_hop_address;
  assign age = cmd_r.now_time - head.qtime;
  assign aged = head.valid && (age > {24'd0, timeout_r});

  logic bad_enq;
  assign bad_enq = in_data.router_id == '0 || in_data.neighbor_interface == '0 ||
                   in_data.next_hop_address == '0 || in_data.ingress_interface == '0 ||
                   in_data.frame_handle == '0 || in_data.frame_length < MinFrame ||
                   in_data.frame_length > maxlen_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE && out_free;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  slot_t new_slot;
  always_comb begin
    new_slot.valid = 1'b1;
    new_slot.router = cmd_r.router_id;
    new_slot.nbr_if = cmd_r.neighbor_interface;
    new_slot.next_hop = cmd_r.next_hop_address;
    new_slot.ingress_if = cmd_r.ingress_interface;
    new_slot.rx_port = cmd_r.ingress_port_number;
    new_slot.egress = cmd_r.expected_egress;
    new_slot.hops = cmd_r.hop_count;
    new_slot.handle = cmd_r.frame_handle;
    new_slot.length = cmd_r.frame_length;
    new_slot.qtime = cmd_r.now_time;
  end

  // the scan pass for enqueue only counts matches and finds a free slot; a second pass writes the slot
  logic write_pass_r, write_pass_nxt;
  logic take_now, exp_now, write_now, room;
  assign take_now = cmd_r.command == CMD_TAKE && key_hit && !taken_r;
  assign exp_now = cmd_r.command == CMD_SWEEP && aged;
  assign write_now = write_pass_r && pos_r == free_pos_r;
  assign shift = state_r == S_SCAN && (!exp_now || out_free);
  assign room = (have_free_r || !head.valid) && (same_r + CntW'(key_hit)) < limit_r;

  always_comb begin
    feed = head;
    if (take_now || exp_now) feed.valid = 1'b0;
    if (write_now) feed = new_slot;
  end

  out_beat_t blank;
  always_comb begin
    blank = '0;
    blank.last = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_nxt = pos_r;
    same_nxt = same_r;
    used_nxt = used_r;
    removed_nxt = removed_r;
    have_free_nxt = have_free_r;
    free_pos_nxt = free_pos_r;
    taken_nxt = taken_r;
    write_pass_nxt = write_pass_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt = in_data;
          pos_nxt = '0;
          same_nxt = '0;
          removed_nxt = '0;
          have_free_nxt = 1'b0;
          taken_nxt = 1'b0;
          write_pass_nxt = 1'b0;
          if ((in_data.command == CMD_ENQ && bad_enq) || in_data.command == CMD_NONE) begin
            out_nxt = blank;
            out_nxt.status = ST_INVALID;
            out_nxt.occupancy = 6'(used_r);
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (shift) begin
          pos_nxt = pos_r + 1'b1;
          if (!head.valid && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_pos_nxt = pos_r;
          end
          if (!write_pass_r && key_hit) same_nxt = same_r + 1'b1;
          if (take_now) begin
            taken_nxt = 1'b1;
            used_nxt = used_r - 1'b1;
            out_nxt = blank;
            out_nxt.status = ST_TAKEN;
            out_nxt.out_ingress_interface = head.ingress_if;
            out_nxt.out_ingress_port = head.rx_port;
            out_nxt.out_hop_count = head.hops;
            out_nxt.out_expected_egress = head.egress;
            out_nxt.out_frame_handle = head.handle;
            out_nxt.out_frame_length = head.length;
            out_nxt.out_queued_time = head.qtime;
            out_nxt.occupancy = 6'(used_r - 1'b1);
          end
          if (exp_now) begin
            used_nxt = used_r - 1'b1;
            removed_nxt = removed_r + 1'b1;
            out_nxt = '0;
            out_nxt.status = ST_EXPIRED;
            out_nxt.out_frame_handle = head.handle;
            out_nxt.occupancy = 6'(used_r - 1'b1);
            out_valid_nxt = 1'b1;
          end
          if (write_now) used_nxt = used_r + 1'b1;
          if (pos_r == IdxW'(TableDepth - 1)) begin
            state_nxt = S_OUT;
            if (cmd_r.command == CMD_ENQ && !write_pass_r && room) begin
              write_pass_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          write_pass_nxt = 1'b0;
          case (cmd_r.command)
            CMD_ENQ: begin
              out_nxt = blank;
              out_nxt.status = write_pass_r ? ST_ACCEPTED : ST_OVERFLOW;
              out_nxt.occupancy = 6'(used_r);
            end
            CMD_TAKE: begin
              if (!taken_r) begin
                out_nxt = blank;
                out_nxt.status = ST_NOT_FOUND;
                out_nxt.occupancy = 6'(used_r);
              end
            end
            default: begin
              out_nxt = blank;
              out_nxt.status = ST_SWEEP_DONE;
              out_nxt.expired_total = 6'(removed_r);
              out_nxt.occupancy = 6'(used_r);
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r <= '0;
      limit_r <= 6'd4;
      timeout_r <= 40'd1000000000;
      maxlen_r <= 14'd9216;
      write_pass_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LIMIT:   limit_r <= cfg_wdata[5:0];
          REG_TIMEOUT: timeout_r <= cfg_wdata;
          REG_MAXLEN:  maxlen_r <= cfg_wdata[13:0];
          default: ;
        endcase
      end
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r <= used_nxt;
      write_pass_r <= write_pass_nxt;
      cmd_r <= cmd_nxt;
      out_r <= out_nxt;
      pos_r <= pos_nxt;
      same_r <= same_nxt;
      removed_r <= removed_nxt;
      have_free_r <= have_free_nxt;
      free_pos_r <= free_pos_nxt;
      taken_r <= taken_nxt;
    end
  end
endmodule
`default_nettype wire
